@@ sv/debounced_key_slot_transmitter_assert.svh @@
// Assertion macros shared by the debounced key slot transmitter modules.
`ifndef DEBOUNCED_KEY_SLOT_TRANSMITTER_ASSERT_SVH
`define DEBOUNCED_KEY_SLOT_TRANSMITTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DKST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DKST_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define DKST_ASSERT(lbl, clk, rstn, prop, msg)
`define DKST_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ sv/dkst_pkg.sv @@
// Package with widths, limits and register codes of the debounced key slot transmitter.
`default_nettype none
package dkst_pkg;
  localparam int unsigned InputW     = 12;
  localparam int unsigned CountW     = 8;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned SlotCnt    = 2 ** SlotW;
  localparam int unsigned NumKeysDef = 12;
  localparam logic [CountW-1:0] CountMax       = '1;
  localparam logic [CountW-1:0] DebounceRstVal = 8'd50;
  localparam logic [CountW-1:0] SlotRstVal     = 8'd10;

  typedef enum logic {
    RegDebounce = 1'b0,
    RegSlot     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SlotW-1:0] key_code;
    logic [SlotW-1:0] slot_index;
  } result_t;
endpackage
`default_nettype wire

@@ sv/dkst_lane.sv @@
// One key debouncer lane: level history, saturating stability counter and pressed flag.
`default_nettype none
module dkst_lane import dkst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              level_i,
  input  wire logic [CountW-1:0] debounce_ticks_i,
  output logic                   pressed_next_o
);
  logic              prev_q, prev_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              pressed_q;

  always_comb begin
    if (level_i != prev_q) begin
      cnt_d = '0;
    end else if (cnt_q != CountMax) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
    prev_d = level_i;
    pressed_next_o = (cnt_d > debounce_ticks_i) ? !level_i : pressed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 1'b1;
      cnt_q     <= '0;
      pressed_q <= 1'b0;
    end else if (en_i) begin
      prev_q    <= prev_d;
      cnt_q     <= cnt_d;
      pressed_q <= pressed_next_o;
    end
  end

`include "debounced_key_slot_transmitter_assert.svh"
  `DKST_ASSERT(a_change_clears, clk_i, rst_ni, (en_i && level_i != prev_q) |=> (cnt_q == '0), "Level change did not clear the counter.")
  `DKST_ASSERT_NEVER(a_flag_max_hold, clk_i, rst_ni, (en_i && debounce_ticks_i == CountMax && pressed_next_o != pressed_q), "Pressed flag changed at maximal debounce.")
endmodule
`default_nettype wire

@@ sv/dkst_merge.sv @@
// Slot timer, round-robin slot select over the lanes and the output register with skid stage.
`default_nettype none
module dkst_merge import dkst_pkg::*; #(
  parameter int unsigned NUM_KEYS = NumKeysDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [NUM_KEYS-1:0] pressed_next_i,
  input  wire logic [CountW-1:0]   slot_ticks_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output result_t                  result_o
);
  logic [CountW-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [SlotCnt-1:0] pressed_pad;
  logic               fire, push, out_load;
  result_t            res_new, out_q, out_d, skid_q, skid_d;
  logic               out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign pressed_pad = SlotCnt'(pressed_next_i);

  always_comb begin
    elapsed_inc = (elapsed_q != CountMax) ? elapsed_q + 1'b1 : elapsed_q;
    fire        = (elapsed_inc >= slot_ticks_i);
    push        = accept_i && fire;
    elapsed_d   = elapsed_q;
    slot_d      = slot_q;
    if (accept_i) begin
      elapsed_d = fire ? '0 : elapsed_inc;
      if (fire) begin
        slot_d = (slot_q == SlotW'(NUM_KEYS - 1)) ? '0 : slot_q + 1'b1;
      end
    end
    res_new.slot_index = slot_q;
    res_new.key_code   = pressed_pad[slot_q] ? slot_q + 1'b1 : '0;
  end

  always_comb begin
    out_load     = !out_valid_q || out_ready_i;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_load) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = res_new;
        skid_valid_d = push;
      end else begin
        out_d       = res_new;
        out_valid_d = push;
      end
    end else if (push) begin
      skid_d       = res_new;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q    <= '0;
      slot_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      elapsed_q    <= elapsed_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`include "debounced_key_slot_transmitter_assert.svh"
  `DKST_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "Skid stage holds a result while the output register is empty.")
  `DKST_ASSERT(a_slot_range, clk_i, rst_ni, slot_q <= SlotW'(NUM_KEYS - 1), "Current slot out of range.")
  `DKST_ASSERT(a_fire_restarts, clk_i, rst_ni, push |=> (elapsed_q == '0), "Slot timer did not restart after a transmission.")
  `DKST_ASSERT(a_code_matches, clk_i, rst_ni, (out_valid_q && out_q.key_code != '0) |-> (out_q.key_code == out_q.slot_index + 1'b1), "Key code does not match its slot.")
endmodule
`default_nettype wire

@@ sv/debounced_key_slot_transmitter.sv @@
// Top level of the debounced key slot transmitter: configuration registers, lanes and merge.
//
// Each transfer on the input channel (in_valid_i, in_ready_o, key_levels_i) is one
// millisecond tick with the raw active-low key levels. All key debouncers update in
// parallel, one lane per key, so one tick is accepted every clock cycle while in_ready_o
// is high. A slot timer counts ticks; when it reaches slot_ticks, one result is sent on
// the output channel (out_valid_o, out_ready_i, key_code_o, slot_index_o) for the
// current slot, and the slot moves round-robin to the next key. Ticks that end no slot
// give no result. A result is registered in the output register or the skid stage. When
// the receiver stalls, one further result is held in a skid stage and ticks are still
// taken; only once the skid stage is full does in_ready_o fall. Reset clears all keys to
// released, the counters and the slot timer to zero, and the registers to a debounce of
// 50 ticks and a slot period of 10 ticks. The user writes the registers through the APB port
// at byte addresses 0 and 4 only while the block is idle; the block does not enforce it.
`default_nettype none
module debounced_key_slot_transmitter import dkst_pkg::*; #(
  parameter int unsigned NUM_KEYS = NumKeysDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [InputW-1:0] key_levels_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SlotW-1:0]       key_code_o,
  output logic [SlotW-1:0]       slot_index_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  logic [CountW-1:0]   debounce_q, slot_ticks_q;
  logic                accept, wr_en;
  logic [NUM_KEYS-1:0] pressed_next;
  reg_idx_e            reg_idx;
  result_t             result;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRstVal;
      slot_ticks_q <= SlotRstVal;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDebounce: debounce_q   <= pwdata[CountW-1:0];
        RegSlot:     slot_ticks_q <= pwdata[CountW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegDebounce: prdata = 32'(debounce_q);
      RegSlot:     prdata = 32'(slot_ticks_q);
      default:     prdata = '0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    if (k < InputW) begin : g_pin
      assign level = key_levels_i[k];
    end else begin : g_tied
      assign level = 1'b1;
    end
    dkst_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .en_i             (accept),
      .level_i          (level),
      .debounce_ticks_i (debounce_q),
      .pressed_next_o   (pressed_next[k])
    );
  end

  dkst_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pressed_next_i (pressed_next),
    .slot_ticks_i   (slot_ticks_q),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result)
  );

  assign key_code_o   = result.key_code;
  assign slot_index_o = result.slot_index;
endmodule
`default_nettype wire
